FILE: hw/rtl/tpfa_pkg.sv
// shared types, codes and saturation helper for the tpfa transmissibility block
`default_nettype none
package tpfa_pkg;

	// configuration register indexes
	localparam logic REG_TENSOR_MODE = 1'b0;
	localparam logic REG_DIMENSION   = 1'b1;

	// result entry kinds
	localparam logic [2:0] KIND_FLUX        = 3'd0;
	localparam logic [2:0] KIND_FLUX_VEC    = 3'd1;
	localparam logic [2:0] KIND_BOUND_FLUX  = 3'd2;
	localparam logic [2:0] KIND_PRESS_CELL  = 3'd3;
	localparam logic [2:0] KIND_PRESS_FACE  = 3'd4;
	localparam logic [2:0] KIND_BOUND_VEC   = 3'd5;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_ZERO_DIST = 2'd1;
	localparam logic [1:0] ERR_ROBIN    = 2'd2;
	localparam logic [1:0] ERR_UNPAIRED = 2'd3;

	typedef enum logic [2:0] {
		CL_LOAD,
		CL_FIRST,
		CL_SECOND,
		CL_DIRICHLET,
		CL_NEUMANN,
		CL_OTHER
	} class_t;

	typedef struct packed {
		class_t            cls;
		logic              sneg;
		logic [23:0]       face;
		logic [23:0]       cell_id;
		logic [5:0][31:0]  val;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIST_M,
		ST_DIST_A,
		ST_PROJ_M1,
		ST_PROJ_A1,
		ST_PROJ_M2,
		ST_PROJ_A2,
		ST_PROJ_KM,
		ST_PROJ_KA,
		ST_TRM_GO,
		ST_TRM_W,
		ST_SIDE,
		ST_H_MUL,
		ST_H_MA,
		ST_H_DW,
		ST_H_FIN,
		ST_NQ_W,
		ST_EM_M,
		ST_EM_O,
		ST_ERR
	} state_t;

	// magnitude plus sign to a vb-bit signed value, saturated
	function automatic logic [63:0] sat_mag(logic neg, logic [127:0] m, int unsigned vb);
		logic [127:0] lim;
		logic [127:0] r;
		lim = 128'(1) << (vb - 1);
		if (neg) begin
			if (m > lim) r = -lim;
			else r = -m;
		end else begin
			if (m >= lim) r = lim - 128'(1);
			else r = m;
		end
		return r[63:0];
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/tpfa_front.sv
// front end: accepts input beats, classifies the operation, two-entry queue
`default_nettype none
module tpfa_front #(
	parameter int INDEX_BITS = 24
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        operation,
	input  wire logic              sign_negative,
	input  wire logic [23:0]       face_index,
	input  wire logic [23:0]       cell_index,
	input  wire logic [5:0][31:0]  vals,
	output tpfa_pkg::queue_t       q,
	input  wire logic              pop
);
	localparam int IW = (INDEX_BITS < 24) ? INDEX_BITS : 24;
	localparam logic [23:0] IMASK = 24'((64'(1) << IW) - 64'(1));

	tpfa_pkg::item_t mem_q [2];
	tpfa_pkg::item_t new_item;
	logic [1:0] count_q;
	logic       wr_q, rd_q;
	logic       push, take;

	always_comb begin
		new_item.sneg    = sign_negative;
		new_item.face    = face_index & IMASK;
		new_item.cell_id = cell_index & IMASK;
		new_item.val     = vals;
		unique case (operation)
			3'd0: new_item.cls = tpfa_pkg::CL_LOAD;
			3'd1: new_item.cls = tpfa_pkg::CL_FIRST;
			3'd2: new_item.cls = tpfa_pkg::CL_SECOND;
			3'd3: new_item.cls = tpfa_pkg::CL_DIRICHLET;
			3'd4: new_item.cls = tpfa_pkg::CL_NEUMANN;
			default: new_item.cls = tpfa_pkg::CL_OTHER;
		endcase
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign take     = pop && (count_q != 2'd0);
	assign q.valid  = (count_q != 2'd0);
	assign q.item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= new_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (take) rd_q <= ~rd_q;
			if (push && !take) count_q <= count_q + 2'd1;
			else if (take && !push) count_q <= count_q - 2'd1;
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/tpfa_div.sv
// iterative fixed-point divider, one quotient bit per cycle, rounded and saturated
`default_nettype none
module tpfa_div #(
	parameter int VALUE_BITS    = 32,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic signed [VALUE_BITS-1:0] a,
	input  wire logic signed [VALUE_BITS-1:0] b,
	output logic                              done,
	output logic signed [VALUE_BITS-1:0]      res
);
	localparam int V  = VALUE_BITS;
	localparam int F  = FRACTION_BITS;
	localparam int NW = V + F;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] rq_q;
	logic [V-1:0]  rem_q, mb_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, fin_q, done_q, neg_q;
	logic signed [V-1:0] res_q;

	logic [V-1:0] ma, mb;
	logic [V:0]   rem2;
	logic         ge;
	logic [NW:0]  qr;

	assign ma   = a[V-1] ? (V'(0) - a) : a;
	assign mb   = b[V-1] ? (V'(0) - b) : b;
	assign rem2 = {rem_q, rq_q[NW-1]};
	assign ge   = rem2 >= {1'b0, mb_q};
	// round half away from zero on the remainder
	assign qr   = {1'b0, rq_q} + (NW+1)'({rem_q, 1'b0} >= {1'b0, mb_q});

	assign done = done_q;
	assign res  = res_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rq_q  <= NW'(ma) << F;
			rem_q <= '0;
			mb_q  <= mb;
			neg_q <= a[V-1] ^ b[V-1];
			if (b == '0) begin
				if (a == '0) res_q <= '0;
				else if (a[V-1]) res_q <= {1'b1, {(V-1){1'b0}}};
				else res_q <= {1'b0, {(V-1){1'b1}}};
			end
		end else if (busy_q) begin
			rem_q <= ge ? V'(rem2 - {1'b0, mb_q}) : V'(rem2);
			rq_q  <= {rq_q[NW-2:0], ge};
		end else if (fin_q) begin
			res_q <= V'(tpfa_pkg::sat_mag(neg_q, 128'(qr), V));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start) begin
				if (b == '0) done_q <= 1'b1;
				else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/tpfa_back.sv
// back end: sequencer with shared multiplier and divider, result register
`default_nettype none
module tpfa_back #(
	parameter int SPACE_DIMS    = 3,
	parameter int VALUE_BITS    = 32,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_write,
	input  wire logic             cfg_index,
	input  wire logic [1:0]       cfg_data,
	input  wire tpfa_pkg::queue_t q,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [2:0]            entry_kind,
	output logic [23:0]           row_index,
	output logic [25:0]           column_index,
	output logic [31:0]           value,
	output logic [1:0]            error,
	output logic                  last
);
	localparam int V  = VALUE_BITS;
	localparam int F  = FRACTION_BITS;
	localparam int SD = SPACE_DIMS;
	localparam logic signed [V-1:0] VMAX = {1'b0, {(V-1){1'b1}}};
	localparam logic signed [V-1:0] VMIN = {1'b1, {(V-1){1'b0}}};
	localparam logic signed [V-1:0] ONE  = (F <= V - 2) ? (V'(1) << F) : VMAX;
	localparam logic signed [V-1:0] MONE = V'(0) - ONE;
	localparam logic [2*V-1:0] HALF = (2*V)'(1) << (F - 1);

	function automatic logic signed [V-1:0] add_s(logic signed [V-1:0] x,
	                                              logic signed [V-1:0] y);
		logic [V:0] s;
		s = {x[V-1], x} + {y[V-1], y};
		if (s[V] != s[V-1]) return s[V] ? VMIN : VMAX;
		return V'(s);
	endfunction

	function automatic logic signed [V-1:0] neg_s(logic signed [V-1:0] x);
		return (x == VMIN) ? VMAX : (V'(0) - x);
	endfunction

	function automatic logic signed [V-1:0] rd_val(logic [31:0] x);
		logic signed [63:0] s;
		s = 64'(signed'(x));
		return V'(tpfa_pkg::sat_mag(x[31], 128'(x[31] ? -s : s), V));
	endfunction

	tpfa_pkg::state_t state_q, state_d;

	// configuration
	logic [1:0] mode_q, dim_q;

	// item being worked
	tpfa_pkg::class_t cls_q;
	logic        sneg_q;
	logic [23:0] face_q, cell_q;
	logic signed [V-1:0] n_q [3];
	logic signed [V-1:0] d_q [3];

	// kept state
	logic signed [V-1:0] kt_q [6];
	logic signed [V-1:0] held_trm_q;
	logic signed [V-1:0] held_vec_q [3];
	logic        held_sneg_q, pending_q;
	logic [23:0] held_face_q, held_cell_q;

	// scratch
	logic signed [V-1:0] acc_q, tmp_q, dist_q, trm_q, sa_q, sb_q, nq_q;
	logic [1:0] i_q, j_q;
	logic [2:0] k_q;
	logic [1:0] err_q;

	// multiplier
	logic                mul_go;
	logic signed [V-1:0] mul_a, mul_b, mres;
	logic [2*V-1:0]      pm_s1;
	logic                pneg_s1;
	logic [V-1:0]        ma, mb;

	// divider
	logic                div_go, div_done;
	logic signed [V-1:0] div_a, div_b, div_res;

	// result register
	logic        ov_q, out_ld, last_q;
	logic [2:0]  kind_q;
	logic [23:0] row_q;
	logic [25:0] col_q;
	logic signed [V-1:0] val_q;
	logic [1:0]  erro_q;

	logic [1:0] lim;
	logic       full, iso, i_end, j_end;
	logic [2:0] kidx;
	logic signed [V-1:0] acc_n;

	// entry decode
	logic [2:0]  e_kind;
	logic [23:0] e_row;
	logic [25:0] e_col;
	logic        e_mul, e_last;
	logic signed [V-1:0] e_ma, e_mb, e_val;
	logic [1:0]  comp;
	logic [23:0] e_cell;
	logic        e_cellcol;

	assign lim   = ((SD == 3) && (dim_q == 2'd3)) ? 2'd2 : 2'd1;
	assign full  = mode_q[1];
	assign iso   = (mode_q == 2'd0);
	assign i_end = (i_q == lim);
	assign j_end = (j_q == lim);
	assign kidx  = (!full || (i_q == j_q)) ? {1'b0, i_q} : (3'd2 + {1'b0, i_q} + {1'b0, j_q});
	assign acc_n = add_s(acc_q, mres);

	assign ma = mul_a[V-1] ? (V'(0) - mul_a) : mul_a;
	assign mb = mul_b[V-1] ? (V'(0) - mul_b) : mul_b;
	assign mres = V'(tpfa_pkg::sat_mag(pneg_s1, 128'((pm_s1 + HALF) >> F), V));

	always_ff @(posedge clk) begin
		if (mul_go) begin
			pm_s1   <= (2*V)'(ma) * (2*V)'(mb);
			pneg_s1 <= mul_a[V-1] ^ mul_b[V-1];
		end
	end

	tpfa_div #(.VALUE_BITS(V), .FRACTION_BITS(F)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_go),
		.a     (div_a),
		.b     (div_b),
		.done  (div_done),
		.res   (div_res)
	);

	// what result k of the current item holds
	always_comb begin
		int kk;
		kk = int'(k_q);
		e_kind = tpfa_pkg::KIND_FLUX;
		e_mul  = 1'b0;
		e_ma   = sa_q;
		e_mb   = d_q[0];
		e_val  = '0;
		e_last = 1'b0;
		e_cell = cell_q;
		e_cellcol = 1'b1;
		comp   = 2'd0;
		e_row  = (cls_q == tpfa_pkg::CL_SECOND) ? held_face_q : face_q;
		priority case (cls_q)
			tpfa_pkg::CL_SECOND: begin
				e_last = (kk == 1 + 2*SD);
				if (kk == 0) begin
					e_cell = held_cell_q;
					e_val  = sa_q;
				end else if (kk == 1) begin
					e_val = sb_q;
				end else if (kk < 2 + SD) begin
					comp   = 2'(kk - 2);
					e_kind = tpfa_pkg::KIND_FLUX_VEC;
					e_cell = held_cell_q;
					e_mul  = 1'b1;
					e_ma   = sa_q;
					e_mb   = held_vec_q[comp];
				end else begin
					comp   = 2'(kk - 2 - SD);
					e_kind = tpfa_pkg::KIND_FLUX_VEC;
					e_mul  = 1'b1;
					e_ma   = sb_q;
					e_mb   = d_q[comp];
				end
			end
			tpfa_pkg::CL_DIRICHLET: begin
				e_last = (kk == SD + 2);
				if (kk == 0) begin
					e_val = sa_q;
				end else if (kk <= SD) begin
					comp   = 2'(kk - 1);
					e_kind = tpfa_pkg::KIND_FLUX_VEC;
					e_mul  = 1'b1;
					e_mb   = d_q[comp];
				end else if (kk == SD + 1) begin
					e_kind = tpfa_pkg::KIND_BOUND_FLUX;
					e_cellcol = 1'b0;
					e_val  = neg_s(sa_q);
				end else begin
					e_kind = tpfa_pkg::KIND_PRESS_FACE;
					e_cellcol = 1'b0;
					e_val  = ONE;
				end
			end
			default: begin
				// neumann
				e_last = (kk == SD + 2);
				if (kk == 0) begin
					e_kind = tpfa_pkg::KIND_BOUND_FLUX;
					e_cellcol = 1'b0;
					e_val  = sneg_q ? MONE : ONE;
				end else if (kk == 1) begin
					e_kind = tpfa_pkg::KIND_PRESS_CELL;
					e_val  = ONE;
				end else if (kk == 2) begin
					e_kind = tpfa_pkg::KIND_PRESS_FACE;
					e_cellcol = 1'b0;
					e_val  = nq_q;
				end else begin
					comp   = 2'(kk - 3);
					e_kind = tpfa_pkg::KIND_BOUND_VEC;
					e_val  = d_q[comp];
				end
			end
		endcase
		// vector entries sit at cell*dims+component, scalar cell entries at the cell index
		if (!e_cellcol) e_col = 26'(face_q);
		else if (e_kind == tpfa_pkg::KIND_FLUX_VEC || e_kind == tpfa_pkg::KIND_BOUND_VEC)
			e_col = 26'(e_cell) * 26'(SD) + 26'(comp);
		else e_col = 26'(e_cell);
	end

	// next state and strobes
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		mul_go  = 1'b0;
		mul_a   = d_q[i_q];
		mul_b   = d_q[i_q];
		div_go  = 1'b0;
		div_a   = acc_q;
		div_b   = dist_q;
		out_ld  = 1'b0;
		unique case (state_q)
			tpfa_pkg::ST_IDLE: begin
				if (q.valid) begin
					pop     = 1'b1;
					state_d = tpfa_pkg::ST_DECODE;
				end
			end
			tpfa_pkg::ST_DECODE: begin
				if (cls_q == tpfa_pkg::CL_LOAD) state_d = tpfa_pkg::ST_IDLE;
				else if (cls_q == tpfa_pkg::CL_SECOND && !pending_q) state_d = tpfa_pkg::ST_ERR;
				else state_d = tpfa_pkg::ST_DIST_M;
			end
			tpfa_pkg::ST_DIST_M: begin
				mul_go  = 1'b1;
				state_d = tpfa_pkg::ST_DIST_A;
			end
			tpfa_pkg::ST_DIST_A: begin
				if (!i_end) state_d = tpfa_pkg::ST_DIST_M;
				else if (acc_n == '0) state_d = tpfa_pkg::ST_ERR;
				else state_d = tpfa_pkg::ST_PROJ_M1;
			end
			tpfa_pkg::ST_PROJ_M1: begin
				mul_go  = 1'b1;
				mul_a   = n_q[i_q];
				mul_b   = full ? d_q[j_q] : d_q[i_q];
				state_d = tpfa_pkg::ST_PROJ_A1;
			end
			tpfa_pkg::ST_PROJ_A1: begin
				if (!iso) state_d = tpfa_pkg::ST_PROJ_M2;
				else if (i_end) state_d = tpfa_pkg::ST_PROJ_KM;
				else state_d = tpfa_pkg::ST_PROJ_M1;
			end
			tpfa_pkg::ST_PROJ_M2: begin
				mul_go  = 1'b1;
				mul_a   = tmp_q;
				mul_b   = kt_q[kidx];
				state_d = tpfa_pkg::ST_PROJ_A2;
			end
			tpfa_pkg::ST_PROJ_A2: begin
				if (i_end && (!full || j_end)) state_d = tpfa_pkg::ST_TRM_GO;
				else state_d = tpfa_pkg::ST_PROJ_M1;
			end
			tpfa_pkg::ST_PROJ_KM: begin
				mul_go  = 1'b1;
				mul_a   = kt_q[0];
				mul_b   = acc_q;
				state_d = tpfa_pkg::ST_PROJ_KA;
			end
			tpfa_pkg::ST_PROJ_KA: state_d = tpfa_pkg::ST_TRM_GO;
			tpfa_pkg::ST_TRM_GO: begin
				div_go  = 1'b1;
				state_d = tpfa_pkg::ST_TRM_W;
			end
			tpfa_pkg::ST_TRM_W: begin
				if (div_done) state_d = tpfa_pkg::ST_SIDE;
			end
			tpfa_pkg::ST_SIDE: begin
				priority case (cls_q)
					tpfa_pkg::CL_FIRST: state_d = tpfa_pkg::ST_IDLE;
					tpfa_pkg::CL_SECOND: begin
						if (add_s(held_trm_q, trm_q) == '0) state_d = tpfa_pkg::ST_H_FIN;
						else state_d = tpfa_pkg::ST_H_MUL;
					end
					tpfa_pkg::CL_DIRICHLET: state_d = tpfa_pkg::ST_EM_M;
					tpfa_pkg::CL_NEUMANN: begin
						div_go  = 1'b1;
						div_a   = MONE;
						div_b   = trm_q;
						state_d = tpfa_pkg::ST_NQ_W;
					end
					default: state_d = tpfa_pkg::ST_ERR;
				endcase
			end
			tpfa_pkg::ST_H_MUL: begin
				mul_go  = 1'b1;
				mul_a   = held_trm_q;
				mul_b   = trm_q;
				state_d = tpfa_pkg::ST_H_MA;
			end
			tpfa_pkg::ST_H_MA: begin
				div_go  = 1'b1;
				div_a   = mres;
				div_b   = acc_q;
				state_d = tpfa_pkg::ST_H_DW;
			end
			tpfa_pkg::ST_H_DW: begin
				if (div_done) state_d = tpfa_pkg::ST_H_FIN;
			end
			tpfa_pkg::ST_H_FIN: state_d = tpfa_pkg::ST_EM_M;
			tpfa_pkg::ST_NQ_W: begin
				if (div_done) state_d = tpfa_pkg::ST_EM_M;
			end
			tpfa_pkg::ST_EM_M: begin
				mul_go  = e_mul;
				mul_a   = e_ma;
				mul_b   = e_mb;
				state_d = tpfa_pkg::ST_EM_O;
			end
			tpfa_pkg::ST_EM_O: begin
				if (!ov_q || out_ready) begin
					out_ld  = 1'b1;
					state_d = e_last ? tpfa_pkg::ST_IDLE : tpfa_pkg::ST_EM_M;
				end
			end
			tpfa_pkg::ST_ERR: begin
				if (!ov_q || out_ready) begin
					out_ld  = 1'b1;
					state_d = tpfa_pkg::ST_IDLE;
				end
			end
			default: state_d = tpfa_pkg::ST_IDLE;
		endcase
	end

	// payload and scratch registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			tpfa_pkg::ST_IDLE: begin
				if (q.valid) begin
					cls_q  <= q.item.cls;
					sneg_q <= q.item.sneg;
					face_q <= q.item.face;
					cell_q <= q.item.cell_id;
					for (int m = 0; m < 3; m++) begin
						n_q[m] <= rd_val(q.item.val[m]);
						d_q[m] <= rd_val(q.item.val[3+m]);
					end
				end
			end
			tpfa_pkg::ST_DECODE: begin
				acc_q <= '0;
				i_q   <= 2'd0;
				j_q   <= 2'd0;
				err_q <= tpfa_pkg::ERR_UNPAIRED;
			end
			tpfa_pkg::ST_DIST_A: begin
				err_q <= tpfa_pkg::ERR_ZERO_DIST;
				if (!i_end) begin
					acc_q <= acc_n;
					i_q   <= i_q + 2'd1;
				end else begin
					dist_q <= acc_n;
					acc_q  <= '0;
					i_q    <= 2'd0;
					j_q    <= 2'd0;
				end
			end
			tpfa_pkg::ST_PROJ_A1: begin
				if (iso) begin
					acc_q <= acc_n;
					if (!i_end) i_q <= i_q + 2'd1;
				end else begin
					tmp_q <= mres;
				end
			end
			tpfa_pkg::ST_PROJ_A2: begin
				acc_q <= acc_n;
				if (full && !j_end) j_q <= j_q + 2'd1;
				else begin
					j_q <= 2'd0;
					if (!i_end) i_q <= i_q + 2'd1;
				end
			end
			tpfa_pkg::ST_PROJ_KA: acc_q <= mres;
			tpfa_pkg::ST_TRM_W: begin
				if (div_done) trm_q <= sneg_q ? neg_s(div_res) : div_res;
			end
			tpfa_pkg::ST_SIDE: begin
				err_q <= tpfa_pkg::ERR_ROBIN;
				acc_q <= add_s(held_trm_q, trm_q);
				tmp_q <= '0;
				sa_q  <= sneg_q ? neg_s(trm_q) : trm_q;
				k_q   <= 3'd0;
			end
			tpfa_pkg::ST_H_DW: begin
				if (div_done) tmp_q <= div_res;
			end
			tpfa_pkg::ST_H_FIN: begin
				sa_q <= held_sneg_q ? neg_s(tmp_q) : tmp_q;
				sb_q <= sneg_q ? neg_s(tmp_q) : tmp_q;
			end
			tpfa_pkg::ST_NQ_W: begin
				if (div_done) nq_q <= div_res;
			end
			tpfa_pkg::ST_EM_O: begin
				if (out_ld) k_q <= k_q + 3'd1;
			end
			default: ;
		endcase

		if (out_ld) begin
			if (state_q == tpfa_pkg::ST_ERR) begin
				kind_q <= tpfa_pkg::KIND_FLUX;
				row_q  <= face_q;
				col_q  <= '0;
				val_q  <= '0;
				erro_q <= err_q;
				last_q <= 1'b1;
			end else begin
				kind_q <= e_kind;
				row_q  <= e_row;
				col_q  <= e_col;
				val_q  <= e_mul ? mres : e_val;
				erro_q <= tpfa_pkg::ERR_NONE;
				last_q <= e_last;
			end
		end
	end

	// control and kept state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tpfa_pkg::ST_IDLE;
			mode_q      <= 2'd0;
			dim_q       <= 2'd3;
			pending_q   <= 1'b0;
			ov_q        <= 1'b0;
			held_trm_q  <= '0;
			held_sneg_q <= 1'b0;
			held_face_q <= '0;
			held_cell_q <= '0;
			for (int m = 0; m < 3; m++) held_vec_q[m] <= '0;
			for (int m = 0; m < 6; m++) kt_q[m] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				unique case (cfg_index)
					tpfa_pkg::REG_TENSOR_MODE: mode_q <= cfg_data;
					tpfa_pkg::REG_DIMENSION:   dim_q  <= cfg_data;
				endcase
			end
			if (out_ld) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			if (state_q == tpfa_pkg::ST_DECODE && cls_q == tpfa_pkg::CL_LOAD) begin
				for (int m = 0; m < 3; m++) begin
					kt_q[m]   <= n_q[m];
					kt_q[3+m] <= d_q[m];
				end
			end
			// zero distance on an internal side drops the held side
			if (state_q == tpfa_pkg::ST_DIST_A && i_end && acc_n == '0 &&
			    (cls_q == tpfa_pkg::CL_FIRST || cls_q == tpfa_pkg::CL_SECOND))
				pending_q <= 1'b0;
			if (state_q == tpfa_pkg::ST_SIDE) begin
				if (cls_q == tpfa_pkg::CL_FIRST) begin
					held_trm_q  <= trm_q;
					held_sneg_q <= sneg_q;
					held_face_q <= face_q;
					held_cell_q <= cell_q;
					for (int m = 0; m < 3; m++) held_vec_q[m] <= d_q[m];
					pending_q   <= 1'b1;
				end else if (cls_q == tpfa_pkg::CL_SECOND) begin
					pending_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid    = ov_q;
	assign entry_kind   = kind_q;
	assign row_index    = row_q;
	assign column_index = col_q;
	assign value        = 32'(val_q);
	assign error        = erro_q;
	assign last         = last_q;
endmodule
`default_nettype wire

FILE: hw/rtl/tpfa_face_transmissibility_top.sv
// top level of the tpfa face transmissibility block
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------------
//  input    | in_valid / in_ready   | operation sign_negative face_index cell_index
//           |                       | value_0 .. value_5
//  result   | out_valid / out_ready | entry_kind row_index column_index value error
//           |                       | last
//  config   | cfg_write             | cfg_index cfg_data
//
// a load only writes the tensor; a side computes its distance, then its isotropic,
// diagonal or full projection, then one division in the shared bit-serial divider;
// a second side adds a multiply and one more division (unless the two halves sum
// to zero), a neumann side one more division; each result then passes through
// the result register, using the single shared multiplier where it needs one.
// reset clears the queue, the held side and the tensor, and sets dimension to 3.
// a two-beat input queue keeps accepting, until full, while the back end waits on out_ready.
`default_nettype none
module tpfa_face_transmissibility_top #(
	parameter int SPACE_DIMS    = 3,
	parameter int VALUE_BITS    = 32,
	parameter int FRACTION_BITS = 16,
	parameter int INDEX_BITS    = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic        cfg_index,
	input  wire logic [1:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  operation,
	input  wire logic        sign_negative,
	input  wire logic [23:0] face_index,
	input  wire logic [23:0] cell_index,
	input  wire logic [31:0] value_0,
	input  wire logic [31:0] value_1,
	input  wire logic [31:0] value_2,
	input  wire logic [31:0] value_3,
	input  wire logic [31:0] value_4,
	input  wire logic [31:0] value_5,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       entry_kind,
	output logic [23:0]      row_index,
	output logic [25:0]      column_index,
	output logic [31:0]      value,
	output logic [1:0]       error,
	output logic             last
);
	tpfa_pkg::queue_t q;
	logic             pop;
	logic [5:0][31:0] vals;

	assign vals = {value_5, value_4, value_3, value_2, value_1, value_0};

	tpfa_front #(.INDEX_BITS(INDEX_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.sign_negative(sign_negative),
		.face_index   (face_index),
		.cell_index   (cell_index),
		.vals         (vals),
		.q            (q),
		.pop          (pop)
	);

	tpfa_back #(
		.SPACE_DIMS   (SPACE_DIMS),
		.VALUE_BITS   (VALUE_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q           (q),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.entry_kind  (entry_kind),
		.row_index   (row_index),
		.column_index(column_index),
		.value       (value),
		.error       (error),
		.last        (last)
	);
endmodule
`default_nettype wire

FILE: tb/tb_tpfa_face_transmissibility_top.sv
// self-checking testbench for the tpfa face transmissibility block
`timescale 1ns / 100ps
`default_nettype none
module tb_tpfa_face_transmissibility_top;

	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;
	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;
	localparam longint ONE = 64'sd65536;
	localparam int DIMS_MAX = 3;
	localparam int SETTLE_CYCLES = 400;
	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		logic [2:0]  op;
		logic        sneg;
		logic [23:0] face;
		logic [23:0] cell_id;
		logic [31:0] v [6];
	} side_item_t;

	typedef struct {
		logic [2:0]  kind;
		logic [23:0] row;
		logic [25:0] col;
		logic [31:0] val;
		logic [1:0]  err;
		logic        last;
	} entry_t;

	logic clk, arst_n;
	logic cfg_write, cfg_index;
	logic [1:0] cfg_data;
	logic in_valid, in_ready;
	logic [2:0] operation;
	logic sign_negative;
	logic [23:0] face_index, cell_index;
	logic [31:0] value_0, value_1, value_2, value_3, value_4, value_5;
	logic out_valid, out_ready;
	logic [2:0] entry_kind;
	logic [23:0] row_index;
	logic [25:0] column_index;
	logic [31:0] value;
	logic [1:0] error;
	logic last;

	tpfa_face_transmissibility_top dut (.*);

	// predictor state
	longint tensor_k [6];
	longint held_trm;
	logic held_sneg;
	longint held_d [3];
	logic [23:0] held_face, held_cell;
	logic side_held;
	logic [1:0] mode_cfg, dim_cfg;
	longint nv [3], dv [3];

	side_item_t pending_items [$];
	entry_t expected_entries [$];
	side_item_t cur;
	int fails, items_taken, entries_seen, idle_cycles;
	bit took;
	int burst_left, gap_left;
	int rdy_mode, rdy_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint sat(longint x);
		return x > VMAX ? VMAX : (x < VMIN ? VMIN : x);
	endfunction

	function automatic longint from_mag(logic neg, logic [127:0] m);
		if (neg) return m > 128'd2147483648 ? VMIN : -longint'(m[63:0]);
		return m > 128'd2147483647 ? VMAX : longint'(m[63:0]);
	endfunction

	function automatic logic [127:0] magn(longint a);
		return 128'(a < 0 ? -a : a);
	endfunction

	function automatic longint q_mul(longint a, longint b);
		logic [127:0] p;
		p = magn(a) * magn(b) + 128'd32768;
		return from_mag((a < 0) != (b < 0), p >> 16);
	endfunction

	function automatic longint q_div(longint a, longint b);
		logic [127:0] n, mb, q, r;
		if (b == 0) return a > 0 ? VMAX : (a < 0 ? VMIN : 0);
		n = magn(a) << 16;
		mb = magn(b);
		q = n / mb;
		r = n % mb;
		if (r >= mb - r) q = q + 1;
		return from_mag((a < 0) != (b < 0), q);
	endfunction

	// half transmissibility of the side in nv/dv; 0 when distance rounds to zero
	function automatic bit half_trm(logic sneg, output longint trm);
		int dims;
		longint dsq, p, r;
		dims = dim_cfg < 2 ? 2 : (dim_cfg > DIMS_MAX ? DIMS_MAX : int'(dim_cfg));
		dsq = 0;
		p = 0;
		for (int i = 0; i < dims; i++) dsq = sat(dsq + q_mul(dv[i], dv[i]));
		trm = 0;
		if (dsq == 0) return 0;
		if (mode_cfg == 0) begin
			for (int i = 0; i < dims; i++) p = sat(p + q_mul(nv[i], dv[i]));
			p = q_mul(tensor_k[0], p);
		end else if (mode_cfg == 1) begin
			for (int i = 0; i < dims; i++)
				p = sat(p + q_mul(q_mul(nv[i], dv[i]), tensor_k[i]));
		end else begin
			for (int i = 0; i < dims; i++)
				for (int j = 0; j < dims; j++)
					p = sat(p + q_mul(q_mul(nv[i], dv[j]), tensor_k[i == j ? i : 2 + i + j]));
		end
		r = q_div(p, dsq);
		trm = sneg ? sat(-r) : r;
		return 1;
	endfunction

	task automatic push_entry(logic [2:0] kind, logic [23:0] row, longint col, longint val,
			logic [1:0] err, logic lst);
		entry_t e;
		e.kind = kind;
		e.row = row;
		e.col = col[25:0];
		e.val = val[31:0];
		e.err = err;
		e.last = lst;
		expected_entries.insert(expected_entries.size(), e);
	endtask

	task automatic predict_entries(side_item_t it);
		longint trm, t, sum, h, ha, hb;
		if (it.op == tpfa_pkg::CL_LOAD) begin
			for (int i = 0; i < 6; i++) tensor_k[i] = longint'(signed'(it.v[i]));
			return;
		end
		if (it.op == tpfa_pkg::CL_SECOND && !side_held) begin
			push_entry(tpfa_pkg::KIND_FLUX, it.face, 0, 0, tpfa_pkg::ERR_UNPAIRED, 1'b1);
			return;
		end
		for (int i = 0; i < 3; i++) begin
			nv[i] = longint'(signed'(it.v[i]));
			dv[i] = longint'(signed'(it.v[3 + i]));
		end
		if (!half_trm(it.sneg, trm)) begin
			if (it.op == tpfa_pkg::CL_FIRST || it.op == tpfa_pkg::CL_SECOND) side_held = 1'b0;
			push_entry(tpfa_pkg::KIND_FLUX, it.face, 0, 0, tpfa_pkg::ERR_ZERO_DIST, 1'b1);
			return;
		end
		case (it.op)
			tpfa_pkg::CL_FIRST: begin
				held_trm = trm;
				held_sneg = it.sneg;
				for (int i = 0; i < 3; i++) held_d[i] = dv[i];
				held_face = it.face;
				held_cell = it.cell_id;
				side_held = 1'b1;
			end
			tpfa_pkg::CL_SECOND: begin
				sum = sat(held_trm + trm);
				h = sum == 0 ? 0 : q_div(q_mul(held_trm, trm), sum);
				ha = held_sneg ? sat(-h) : h;
				hb = it.sneg ? sat(-h) : h;
				side_held = 1'b0;
				push_entry(tpfa_pkg::KIND_FLUX, held_face, held_cell, ha, tpfa_pkg::ERR_NONE,
					1'b0);
				push_entry(tpfa_pkg::KIND_FLUX, held_face, it.cell_id, hb, tpfa_pkg::ERR_NONE,
					1'b0);
				for (int i = 0; i < 3; i++)
					push_entry(tpfa_pkg::KIND_FLUX_VEC, held_face, held_cell * 3 + i,
						q_mul(ha, held_d[i]), tpfa_pkg::ERR_NONE, 1'b0);
				for (int i = 0; i < 3; i++)
					push_entry(tpfa_pkg::KIND_FLUX_VEC, held_face, it.cell_id * 3 + i,
						q_mul(hb, dv[i]), tpfa_pkg::ERR_NONE, i == 2);
			end
			tpfa_pkg::CL_DIRICHLET: begin
				t = it.sneg ? sat(-trm) : trm;
				push_entry(tpfa_pkg::KIND_FLUX, it.face, it.cell_id, t, tpfa_pkg::ERR_NONE, 1'b0);
				for (int i = 0; i < 3; i++)
					push_entry(tpfa_pkg::KIND_FLUX_VEC, it.face, it.cell_id * 3 + i,
						q_mul(t, dv[i]), tpfa_pkg::ERR_NONE, 1'b0);
				push_entry(tpfa_pkg::KIND_BOUND_FLUX, it.face, it.face, sat(-t),
					tpfa_pkg::ERR_NONE, 1'b0);
				push_entry(tpfa_pkg::KIND_PRESS_FACE, it.face, it.face, ONE,
					tpfa_pkg::ERR_NONE, 1'b1);
			end
			tpfa_pkg::CL_NEUMANN: begin
				push_entry(tpfa_pkg::KIND_BOUND_FLUX, it.face, it.face, it.sneg ? -ONE : ONE,
					tpfa_pkg::ERR_NONE, 1'b0);
				push_entry(tpfa_pkg::KIND_PRESS_CELL, it.face, it.cell_id, ONE,
					tpfa_pkg::ERR_NONE, 1'b0);
				push_entry(tpfa_pkg::KIND_PRESS_FACE, it.face, it.face, q_div(-ONE, trm),
					tpfa_pkg::ERR_NONE, 1'b0);
				for (int i = 0; i < 3; i++)
					push_entry(tpfa_pkg::KIND_BOUND_VEC, it.face, it.cell_id * 3 + i, dv[i],
						tpfa_pkg::ERR_NONE, i == 2);
			end
			default: push_entry(tpfa_pkg::KIND_FLUX, it.face, 0, 0, tpfa_pkg::ERR_ROBIN, 1'b1);
		endcase
	endtask

	task automatic add_item(logic [2:0] op, logic sn, logic [23:0] f, logic [23:0] c,
			logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
			logic [31:0] a3, logic [31:0] a4, logic [31:0] a5);
		side_item_t it;
		it.op = op;
		it.sneg = sn;
		it.face = f;
		it.cell_id = c;
		it.v[0] = a0; it.v[1] = a1; it.v[2] = a2;
		it.v[3] = a3; it.v[4] = a4; it.v[5] = a5;
		pending_items.insert(pending_items.size(), it);
	endtask

	function automatic logic [31:0] rnd_val();
		int k;
		k = $urandom_range(0, 15);
		if (k == 0) return $urandom;
		if (k == 1) return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
		if (k == 2) return 32'h0;
		return 32'($signed($urandom_range(0, 524288)) - 262144);
	endfunction

	function automatic logic [23:0] rnd_index();
		return $urandom_range(0, 7) == 0 ? 24'hffffff : 24'($urandom);
	endfunction

	task automatic add_random(logic [2:0] op);
		add_item(op, 1'($urandom), rnd_index(), rnd_index(), rnd_val(), rnd_val(),
			rnd_val(), rnd_val(), rnd_val(), rnd_val());
	endtask

	task automatic write_reg(logic idx, logic [1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == tpfa_pkg::REG_TENSOR_MODE) mode_cfg = data;
		else dim_cfg = data;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_entries.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// driver: bursts of beats with random gaps
	always @(negedge clk) begin
		if (arst_n && (!in_valid || took)) begin
			took = 1'b0;
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
			end
			if (gap_left > 0 || pending_items.size() == 0) begin
				if (gap_left > 0) gap_left--;
				in_valid <= 1'b0;
			end else begin
				cur = pending_items.pop_front();
				burst_left--;
				in_valid <= 1'b1;
				operation <= cur.op;
				sign_negative <= cur.sneg;
				face_index <= cur.face;
				cell_index <= cur.cell_id;
				value_0 <= cur.v[0]; value_1 <= cur.v[1]; value_2 <= cur.v[2];
				value_3 <= cur.v[3]; value_4 <= cur.v[4]; value_5 <= cur.v[5];
			end
		end
	end

	// receiver stall pattern: always ready, coin flip, or mostly stalled
	always @(negedge clk) begin
		if (rdy_count == 0) begin
			rdy_mode = $urandom_range(0, 2);
			rdy_count = $urandom_range(16, 96);
		end
		rdy_count--;
		case (rdy_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom);
			default: out_ready <= $urandom_range(0, 3) == 0;
		endcase
	end

	// input beats feed the predictor, result beats are checked
	always @(posedge clk) begin
		entry_t e;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_entries(cur);
				took = 1'b1;
				items_taken++;
			end
			if (out_valid && out_ready) begin
				entries_seen++;
				if (expected_entries.size() == 0) begin
					$error("unexpected result beat kind=%0d row=%0d", entry_kind, row_index);
					fails++;
				end else begin
					e = expected_entries.pop_front();
					if (entry_kind !== e.kind) begin
						$error("entry_kind expected %0d actual %0d", e.kind, entry_kind);
						fails++;
					end
					if (row_index !== e.row) begin
						$error("row_index expected %0d actual %0d", e.row, row_index);
						fails++;
					end
					if (column_index !== e.col) begin
						$error("column_index expected %0d actual %0d", e.col, column_index);
						fails++;
					end
					if (value !== e.val) begin
						$error("value expected %h actual %h", e.val, value);
						fails++;
					end
					if (error !== e.err) begin
						$error("error expected %0d actual %0d", e.err, error);
						fails++;
					end
					if (last !== e.last) begin
						$error("last expected %0d actual %0d", e.last, last);
						fails++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)
					|| (!in_valid && expected_entries.size() == 0))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no beat for %0d cycles", IDLE_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int r;
		logic [1:0] phase_mode [7];
		logic [1:0] phase_dim [7];
		phase_mode = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0};
		phase_dim = '{2'd3, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3};
		fails = 0; items_taken = 0; entries_seen = 0; idle_cycles = 0;
		took = 1'b0; burst_left = 0; gap_left = 0; rdy_count = 0; rdy_mode = 0;
		for (int i = 0; i < 6; i++) tensor_k[i] = 0;
		for (int i = 0; i < 3; i++) held_d[i] = 0;
		held_trm = 0; held_sneg = 0; held_face = 0; held_cell = 0; side_held = 0;
		mode_cfg = 2'd0; dim_cfg = 2'd3;
		arst_n = 1'b0;
		cfg_write = 1'b0; cfg_index = 1'b0; cfg_data = 2'd0;
		in_valid = 1'b0; out_ready = 1'b0;
		operation = '0; sign_negative = 1'b0; face_index = '0; cell_index = '0;
		value_0 = '0; value_1 = '0; value_2 = '0; value_3 = '0; value_4 = '0; value_5 = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(tpfa_pkg::REG_TENSOR_MODE, 2'd0);
		write_reg(tpfa_pkg::REG_DIMENSION, 2'd3);
		// directed: every operation and the corner cases
		add_item(tpfa_pkg::CL_LOAD, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0);
		add_item(tpfa_pkg::CL_DIRICHLET, 0, 24'hffffff, 24'hffffff, 32'h10000, 0, 0,
			32'h8000, 0, 0);
		add_item(tpfa_pkg::CL_NEUMANN, 1, 24'hffffff, 24'h0, 32'h10000, 32'h10000, 0,
			32'h8000, 32'h8000, 32'h8000);
		add_item(tpfa_pkg::CL_FIRST, 0, 5, 7, 32'h10000, 0, 0, 32'h10000, 0, 0);
		add_item(tpfa_pkg::CL_SECOND, 1, 9, 8, 32'hffff0000, 0, 0, 32'hffff8000, 0, 0);
		add_item(tpfa_pkg::CL_SECOND, 0, 3, 3, 32'h10000, 0, 0, 32'h10000, 0, 0);
		add_item(tpfa_pkg::CL_FIRST, 0, 11, 12, 32'h10000, 0, 0, 32'h10000, 0, 0);
		add_item(tpfa_pkg::CL_FIRST, 1, 13, 14, 32'h20000, 0, 0, 32'h10000, 32'h10000, 0);
		add_item(tpfa_pkg::CL_SECOND, 0, 15, 16, 32'h10000, 32'h10000, 0, 32'h10000,
			32'h20000, 0);
		add_item(tpfa_pkg::CL_FIRST, 0, 17, 18, 32'h10000, 0, 0, 0, 0, 0);
		add_item(tpfa_pkg::CL_SECOND, 0, 19, 20, 32'h10000, 0, 0, 32'h10000, 0, 0);
		add_item(tpfa_pkg::CL_DIRICHLET, 0, 21, 22, 32'h10000, 0, 0, 32'h1, 32'h1, 32'h1);
		add_item(tpfa_pkg::CL_OTHER, 0, 23, 24, 0, 0, 0, 0, 0, 0);
		add_item(OP_RSVD6, 1, 25, 26, 0, 0, 0, 32'h10000, 0, 0);
		add_item(OP_RSVD7, 0, 27, 28, 0, 0, 0, 32'h10000, 0, 0);
		// opposite half transmissibilities: zero sum
		add_item(tpfa_pkg::CL_FIRST, 0, 29, 30, 32'h10000, 0, 0, 32'h10000, 0, 0);
		add_item(tpfa_pkg::CL_SECOND, 1, 31, 32, 32'h10000, 0, 0, 32'h10000, 0, 0);
		// zero tensor: neumann with zero transmissibility
		add_item(tpfa_pkg::CL_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_item(tpfa_pkg::CL_NEUMANN, 0, 33, 34, 32'h10000, 0, 0, 32'h10000, 0, 0);
		// saturating extremes
		add_item(tpfa_pkg::CL_LOAD, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h80000000);
		add_item(tpfa_pkg::CL_DIRICHLET, 1, 35, 36, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h80000000);
		add_item(tpfa_pkg::CL_NEUMANN, 0, 37, 38, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h7fffffff);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			write_reg(tpfa_pkg::REG_TENSOR_MODE, phase_mode[ph]);
			write_reg(tpfa_pkg::REG_DIMENSION, phase_dim[ph]);
			for (int n = 0; n < 26; n++) begin
				r = $urandom_range(0, 99);
				if (r < 12) add_random(tpfa_pkg::CL_LOAD);
				else if (r < 52) begin
					add_random(tpfa_pkg::CL_FIRST);
					if ($urandom_range(0, 9) == 0) add_random(3'($urandom_range(0, 7)));
					add_random(tpfa_pkg::CL_SECOND);
				end else if (r < 68) add_random(tpfa_pkg::CL_DIRICHLET);
				else if (r < 84) add_random(tpfa_pkg::CL_NEUMANN);
				else if (r < 90) add_random(3'($urandom_range(5, 7)));
				else if (r < 95) add_random(tpfa_pkg::CL_SECOND);
				else add_random(tpfa_pkg::CL_FIRST);
			end
			drain();
		end

		$display("covered %0d input beats and %0d result beats over 8 register settings",
			items_taken, entries_seen);
		$display("tensor modes 0..3 and dimension values 0..3 were exercised");
		if (expected_entries.size() != 0) fails++;
		if (fails == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
`default_nettype wire
